### src/tfb_pkg.sv
// Package for the telemetry frame builder.
// Holds the frame constants, the cell payload type and the frame loader.
// No dependencies.
package tfb_pkg;

	localparam int unsigned FRAME_LEN    = 8;
	localparam logic [7:0]  FRAME_HEADER = 8'h10;
	localparam int unsigned ID_W         = 16;
	localparam int unsigned VALUE_W      = 32;

	// One stored frame byte; last marks the checksum slot
	typedef struct packed {
		logic       valid;
		logic       last;
		logic [7:0] data;
	} cell_t;

	typedef cell_t [FRAME_LEN-1:0] frame_t;

	// Build the eight cells of one frame; the checksum slot holds no data yet
	function automatic frame_t load_frame(input logic [ID_W-1:0] id,
	                                      input logic [VALUE_W-1:0] value);
		frame_t f;
		f[0] = '{valid: 1'b1, last: 1'b0, data: FRAME_HEADER};
		f[1] = '{valid: 1'b1, last: 1'b0, data: id[7:0]};
		f[2] = '{valid: 1'b1, last: 1'b0, data: id[15:8]};
		f[3] = '{valid: 1'b1, last: 1'b0, data: value[7:0]};
		f[4] = '{valid: 1'b1, last: 1'b0, data: value[15:8]};
		f[5] = '{valid: 1'b1, last: 1'b0, data: value[23:16]};
		f[6] = '{valid: 1'b1, last: 1'b0, data: value[31:24]};
		f[7] = '{valid: 1'b1, last: 1'b1, data: 8'h00};
		return f;
	endfunction

endpackage

### src/tfb_cell.sv
// One cell of the frame shift chain.
// Loads a byte in parallel or takes its upstream neighbour's byte; uses tfb_pkg.
module tfb_cell
	import tfb_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  load,
	input  logic  advance,
	input  cell_t load_cell,
	input  cell_t next_cell,
	output cell_t stored
);

	logic       valid_q;
	logic       last_q;
	logic [7:0] data_q;

	// Valid flag: cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= load_cell.valid;
		end else if (advance) begin
			valid_q <= next_cell.valid;
		end
	end

	// Payload: no reset needed
	always_ff @(posedge clk) begin
		if (load) begin
			last_q <= load_cell.last;
			data_q <= load_cell.data;
		end else if (advance) begin
			last_q <= next_cell.last;
			data_q <= next_cell.data;
		end
	end

	assign stored = '{valid: valid_q, last: last_q, data: data_q};

endmodule

### src/tfb_check.sv
// Checksum unit: end-around-carry sum of the bytes sent in the current frame.
// Fills the checksum slot with the complemented sum; uses tfb_pkg.
module tfb_check
	import tfb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       send,
	input  cell_t      head,
	output logic [7:0] byte_out
);

	logic [7:0] sum_q;
	logic [8:0] raw;
	logic [7:0] folded;

	// Add with the carry folded back in; one fold cannot carry again
	always_comb begin
		raw    = {1'b0, sum_q} + {1'b0, head.data};
		folded = raw[7:0] + {7'd0, raw[8]};
	end

	// Accumulate each sent byte, clear after the checksum byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (send) begin
			sum_q <= head.last ? 8'h00 : folded;
		end
	end

	// 0xFF minus the sum is its complement
	assign byte_out = head.last ? ~sum_q : head.data;

`ifndef SYNTHESIS
	a_sum_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(send && head.last) |=> (sum_q == 8'h00))
		else $error("checksum sum not cleared after frame");
`endif

endmodule

### src/telemetry_frame_builder_top.sv
// Top level of the telemetry frame builder.
// Chains tfb_cell instances and the tfb_check unit; uses tfb_pkg.
//
//  channel | dir | signals                      | contents
//  s_      | in  | s_tvalid s_tready s_tdata    | data_id [15:0], data_value [47:16]
//  m_      | out | m_tvalid m_tready m_tdata    | frame_byte [7:0]
//          |     | m_tlast                      | last_byte
//
// Each request produces eight bytes, one per cycle unless the output stalls;
// cell 0 is the output register. A new request is taken in the cycle the
// previous request's last byte leaves, so frames run back to back.
// Reset clears every cell's valid flag and the checksum sum.
// A stalled output holds the whole chain; nothing is dropped.
module telemetry_frame_builder_top
	import tfb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // data_id [15:0], data_value [47:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // frame_byte [7:0]
	output logic        m_tlast    // last_byte
);

	frame_t                  cells;
	frame_t                  loaded;
	logic                    advance;
	logic                    load;
	logic                    send;
	logic [FRAME_LEN-1:0]    vbits;

	// Shift when the head is empty or taken; load once the chain is empty or only the head remains
	always_comb begin
		advance  = !cells[0].valid || m_tready;
		s_tready = advance && !cells[1].valid;
		load     = s_tvalid && s_tready;
		send     = m_tvalid && m_tready;
		loaded   = load_frame(s_tdata[ID_W-1:0], s_tdata[ID_W+VALUE_W-1:ID_W]);
		for (int i = 0; i < FRAME_LEN; i++) begin
			vbits[i] = cells[i].valid;
		end
	end

	// Row of cells, each fed by its upstream neighbour, the last by an empty cell
	for (genvar g = 0; g < FRAME_LEN; g++) begin : g_cell
		cell_t next_cell;
		if (g == FRAME_LEN - 1) begin : g_tail
			assign next_cell = '{valid: 1'b0, last: 1'b0, data: 8'h00};
		end else begin : g_body
			assign next_cell = cells[g+1];
		end
		tfb_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.load      (load),
			.advance   (advance),
			.load_cell (loaded[g]),
			.next_cell (next_cell),
			.stored    (cells[g])
		);
	end

	// Checksum fill on the head byte
	tfb_check u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.send     (send),
		.head     (cells[0]),
		.byte_out (m_tdata)
	);

	assign m_tvalid = cells[0].valid;
	assign m_tlast  = cells[0].last;

`ifndef SYNTHESIS
	a_load_full: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (&vbits))
		else $error("chain not full after loading a request");
	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		((vbits >> 1) & ~vbits) == '0)
		else $error("gap in the cell chain");
	a_last_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> !cells[1].valid)
		else $error("checksum byte not at the end of the chain");
`endif

endmodule
